// ===== sv/cltr_pkg.sv =====
// Shared types, byte codes and the Cyrillic letter table for the transliterator.
// No dependencies.
package cltr_pkg;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [1:0] PP_NONE  = 2'd0;
  localparam logic [1:0] PP_C2    = 2'd1;
  localparam logic [1:0] PP_E2    = 2'd2;
  localparam logic [1:0] PP_E280  = 2'd3;

  localparam logic [7:0] BYTE_WORD_MARK = 8'h01;
  localparam logic [7:0] BYTE_LEAD_LO   = 8'hD0;
  localparam logic [7:0] BYTE_LEAD_HI   = 8'hD3;
  localparam logic [7:0] BYTE_D0        = 8'hD0;
  localparam logic [7:0] BYTE_D1        = 8'hD1;
  localparam logic [7:0] BYTE_HARD_LO   = 8'h8A;
  localparam logic [7:0] BYTE_HARD_UP   = 8'hAA;
  localparam logic [7:0] BYTE_IE_LO     = 8'hB5;
  localparam logic [7:0] BYTE_IE_UP     = 8'h95;
  localparam logic [7:0] BYTE_C2        = 8'hC2;
  localparam logic [7:0] BYTE_E2        = 8'hE2;
  localparam logic [7:0] BYTE_80        = 8'h80;
  localparam logic [7:0] BYTE_LAQUO     = 8'hAB;
  localparam logic [7:0] BYTE_RAQUO     = 8'hBB;
  localparam logic [7:0] BYTE_EMDASH    = 8'h94;
  localparam logic [7:0] BYTE_ENDASH    = 8'h93;
  localparam logic [7:0] BYTE_ELLIPSIS  = 8'hA6;
  localparam logic [7:0] ASCII_APOS     = 8'h27;
  localparam logic [7:0] ASCII_Y_LO     = 8'h79;
  localparam logic [7:0] ASCII_Y_UP     = 8'h59;
  localparam logic [7:0] ASCII_E_LO     = 8'h65;

  typedef struct packed {
    logic [7:0] held_lead;
    logic       lead_pending;
    logic       at_word_start;
    logic       hard_sign_dropped;
    logic [1:0] punct_prefix;
  } cltr_state_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } cltr_res_t;

  typedef struct packed {
    logic       hit;
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } cltr_letter_t;

  localparam cltr_state_t STATE_RESET = '{
    held_lead: 8'h00, lead_pending: 1'b0, at_word_start: 1'b1,
    hard_sign_dropped: 1'b0, punct_prefix: PP_NONE};

  function automatic cltr_letter_t l1(input logic [7:0] b0);
    cltr_letter_t r;
    r.hit = 1'b1;
    r.two = 1'b0;
    r.b0  = b0;
    r.b1  = 8'h00;
    return r;
  endfunction

  function automatic cltr_letter_t l2(input logic [7:0] b0, input logic [7:0] b1);
    cltr_letter_t r;
    r.hit = 1'b1;
    r.two = 1'b1;
    r.b0  = b0;
    r.b1  = b1;
    return r;
  endfunction

  function automatic cltr_letter_t letter_lookup(input logic [7:0] lead,
                                                 input logic [7:0] trail);
    cltr_letter_t r;
    r = '0;
    unique case ({lead, trail})
      16'hD0B0: r = l1(8'h61);
      16'hD0B1: r = l1(8'h62);
      16'hD0B2: r = l1(8'h76);
      16'hD0B3: r = l1(8'h67);
      16'hD293: r = l2(8'hC4, 8'hA1);
      16'hD0B4: r = l1(8'h64);
      16'hD0B5: r = l1(8'h65);
      16'hD191: r = l2(8'h79, 8'h6F);
      16'hD0B6: r = l2(8'hC5, 8'hBE);
      16'hD0B7: r = l1(8'h7A);
      16'hD0B8: r = l1(8'h69);
      16'hD3A3: r = l2(8'hC4, 8'hAB);
      16'hD0B9: r = l1(8'h79);
      16'hD0BA: r = l1(8'h6B);
      16'hD29B: r = l1(8'h71);
      16'hD0BB: r = l1(8'h6C);
      16'hD0BC: r = l1(8'h6D);
      16'hD0BD: r = l1(8'h6E);
      16'hD0BE: r = l1(8'h6F);
      16'hD0BF: r = l1(8'h70);
      16'hD180: r = l1(8'h72);
      16'hD181: r = l1(8'h73);
      16'hD182: r = l1(8'h74);
      16'hD183: r = l1(8'h75);
      16'hD3AF: r = l2(8'hC5, 8'hAB);
      16'hD184: r = l1(8'h66);
      16'hD185: r = l1(8'h78);
      16'hD2B3: r = l1(8'h68);
      16'hD187: r = l2(8'hC4, 8'h8D);
      16'hD2B7: r = l1(8'h6A);
      16'hD188: r = l2(8'hC5, 8'hA1);
      16'hD18D: r = l1(8'h65);
      16'hD18E: r = l2(8'h79, 8'h75);
      16'hD18F: r = l2(8'h79, 8'h61);
      16'hD090: r = l1(8'h41);
      16'hD091: r = l1(8'h42);
      16'hD092: r = l1(8'h56);
      16'hD093: r = l1(8'h47);
      16'hD292: r = l2(8'hC4, 8'hA0);
      16'hD094: r = l1(8'h44);
      16'hD095: r = l1(8'h45);
      16'hD081: r = l2(8'h59, 8'h6F);
      16'hD096: r = l2(8'hC5, 8'hBD);
      16'hD097: r = l1(8'h5A);
      16'hD098: r = l1(8'h49);
      16'hD3A2: r = l2(8'hC4, 8'hAA);
      16'hD099: r = l1(8'h59);
      16'hD09A: r = l1(8'h4B);
      16'hD29A: r = l1(8'h51);
      16'hD09B: r = l1(8'h4C);
      16'hD09C: r = l1(8'h4D);
      16'hD09D: r = l1(8'h4E);
      16'hD09E: r = l1(8'h4F);
      16'hD09F: r = l1(8'h50);
      16'hD0A0: r = l1(8'h52);
      16'hD0A1: r = l1(8'h53);
      16'hD0A2: r = l1(8'h54);
      16'hD0A3: r = l1(8'h55);
      16'hD3AE: r = l2(8'hC5, 8'hAA);
      16'hD0A4: r = l1(8'h46);
      16'hD0A5: r = l1(8'h58);
      16'hD2B2: r = l1(8'h48);
      16'hD0A7: r = l2(8'hC4, 8'h8C);
      16'hD2B6: r = l1(8'h4A);
      16'hD0A8: r = l2(8'hC5, 8'hA0);
      16'hD0AD: r = l1(8'h45);
      16'hD0AE: r = l2(8'h59, 8'h75);
      16'hD0AF: r = l2(8'h59, 8'h61);
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/cyrillic_latin_transliterator.sv =====
// Tajik Cyrillic to Latin UTF-8 transliterator: input register, word state,
// translation logic and result register. Depends on cltr_pkg, cltr_xlat, cltr_outq.
//
//   channel | ports                          | beat
//   input   | in_valid in_stall in_cmd in_byte | one text byte or end of text
//   result  | out_valid out_stall out_byte out_last | one Latin byte
//
// One input beat per cycle, while out_stall is low, when each causes at most
// one result byte; an item with two result bytes holds the result register
// until both are sent. Bytes pass the input register, then the result register.
// Reset (rst_n low, synchronous) empties both registers and puts the word state
// at text start. A stalled result backs up into the input register, then in_stall.
module cyrillic_latin_transliterator import cltr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_cmd_r;
  logic [7:0]  s1_byte_r;
  cltr_state_t st_r, st_nxt, st_calc;
  cltr_res_t   res;
  logic        can_load;
  logic        adv;
  logic        accept;

  cltr_xlat u_xlat (
    .st      (st_r),
    .cmd     (s1_cmd_r),
    .in_byte (s1_byte_r),
    .st_nxt  (st_calc),
    .res     (res)
  );

  cltr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  assign adv      = s1_valid_r && (can_load || res.cnt == 2'd0);
  assign in_stall = s1_valid_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    st_nxt = adv ? st_calc : st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      st_r       <= STATE_RESET;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      st_r       <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r  <= in_cmd;
      s1_byte_r <= in_byte;
    end
  end

endmodule

// ===== sv/cltr_xlat.sv =====
// Combinational byte translation: word state and one input beat in, next state
// and up to two result bytes out. Depends on cltr_pkg.
module cltr_xlat import cltr_pkg::*; (
  input  cltr_state_t st,
  input  logic        cmd,
  input  logic [7:0]  in_byte,
  output cltr_state_t st_nxt,
  output cltr_res_t   res
);

  typedef struct packed {
    cltr_state_t st;
    logic        emit;
  } fresh_t;

  function automatic logic is_break(input logic [7:0] b);
    logic r;
    case (b) inside
      8'h20, 8'h09, 8'h0A, 8'h0D, 8'h2C, 8'h2E, 8'h21, 8'h3F,
      8'h3B, 8'h3A, 8'h28, 8'h29, 8'h5B, 8'h5D: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic fresh_t fresh(input cltr_state_t s, input logic [7:0] b);
    fresh_t r;
    r.st   = s;
    r.emit = 1'b0;
    if (b == BYTE_WORD_MARK) begin
      r.st.at_word_start     = 1'b1;
      r.st.hard_sign_dropped = 1'b0;
      r.st.punct_prefix      = PP_NONE;
    end else if (b >= BYTE_LEAD_LO && b <= BYTE_LEAD_HI) begin
      r.st.held_lead    = b;
      r.st.lead_pending = 1'b1;
      r.st.punct_prefix = PP_NONE;
    end else begin
      r.emit = 1'b1;
      if (is_break(b) ||
          (s.punct_prefix == PP_C2 && (b == BYTE_LAQUO || b == BYTE_RAQUO)) ||
          (s.punct_prefix == PP_E280 &&
           (b == BYTE_EMDASH || b == BYTE_ENDASH || b == BYTE_ELLIPSIS))) begin
        r.st.at_word_start     = 1'b1;
        r.st.hard_sign_dropped = 1'b0;
        r.st.punct_prefix      = PP_NONE;
      end else begin
        if (s.punct_prefix == PP_E2 && b == BYTE_80) begin
          r.st.punct_prefix = PP_E280;
        end else if (b == BYTE_C2) begin
          r.st.punct_prefix = PP_C2;
        end else if (b == BYTE_E2) begin
          r.st.punct_prefix = PP_E2;
        end else begin
          r.st.punct_prefix = PP_NONE;
        end
        r.st.at_word_start     = 1'b0;
        r.st.hard_sign_dropped = 1'b0;
      end
    end
    return r;
  endfunction

  cltr_letter_t lt;
  fresh_t       fr_direct;
  fresh_t       fr_after;
  cltr_state_t  st_pair;
  logic         hard_sign;
  logic         ie_start;

  assign lt        = letter_lookup(st.held_lead, in_byte);
  assign hard_sign = (st.held_lead == BYTE_D1 && in_byte == BYTE_HARD_LO) ||
                     (st.held_lead == BYTE_D0 && in_byte == BYTE_HARD_UP);
  assign ie_start  = st.at_word_start && st.held_lead == BYTE_D0 &&
                     (in_byte == BYTE_IE_LO || in_byte == BYTE_IE_UP);
  assign fr_direct = fresh(st, in_byte);

  always_comb begin
    st_pair = st;
    st_pair.lead_pending      = 1'b0;
    st_pair.held_lead         = 8'h00;
    st_pair.at_word_start     = 1'b0;
    st_pair.hard_sign_dropped = 1'b0;
  end

  assign fr_after = fresh(st_pair, in_byte);

  always_comb begin
    st_nxt = st;
    res    = '0;
    if (cmd == CMD_END) begin
      if (st.lead_pending) begin
        res.cnt = 2'd1;
        res.b0  = st.held_lead;
      end
      st_nxt = STATE_RESET;
    end else if (st.lead_pending) begin
      st_nxt = st_pair;
      if (hard_sign) begin
        if (st.at_word_start && !st.hard_sign_dropped) begin
          st_nxt.at_word_start     = st.at_word_start;
          st_nxt.hard_sign_dropped = 1'b1;
        end else begin
          res.cnt = 2'd1;
          res.b0  = ASCII_APOS;
        end
      end else if (ie_start) begin
        res.cnt = 2'd2;
        res.b0  = (in_byte == BYTE_IE_LO) ? ASCII_Y_LO : ASCII_Y_UP;
        res.b1  = ASCII_E_LO;
      end else if (lt.hit) begin
        res.cnt = lt.two ? 2'd2 : 2'd1;
        res.b0  = lt.b0;
        res.b1  = lt.b1;
      end else begin
        st_nxt  = fr_after.st;
        res.cnt = fr_after.emit ? 2'd2 : 2'd1;
        res.b0  = st.held_lead;
        res.b1  = in_byte;
      end
    end else begin
      st_nxt  = fr_direct.st;
      res.cnt = fr_direct.emit ? 2'd1 : 2'd0;
      res.b0  = in_byte;
    end
  end

endmodule

// ===== sv/cltr_outq.sv =====
// Result register: holds up to two bytes of one item and sends them one beat
// per cycle while out_stall is low. Depends on cltr_pkg.
module cltr_outq import cltr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  cltr_res_t  res,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] b0_r, b0_nxt;
  logic [7:0] b1_r, b1_nxt;
  logic       take;

  assign take      = (cnt_r != 2'd0) && !out_stall;
  assign can_load  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && take);
  assign out_valid = (cnt_r != 2'd0);
  assign out_byte  = b0_r;
  assign out_last  = (cnt_r == 2'd1);

  always_comb begin
    cnt_nxt = cnt_r;
    b0_nxt  = b0_r;
    b1_nxt  = b1_r;
    if (take) begin
      cnt_nxt = cnt_r - 2'd1;
      b0_nxt  = b1_r;
    end
    if (load && res.cnt != 2'd0) begin
      cnt_nxt = res.cnt;
      b0_nxt  = res.b0;
      b1_nxt  = res.b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b0_r <= b0_nxt;
    b1_r <= b1_nxt;
  end

endmodule
